/* hw/rtl/akf_pkg.sv */
// shared types, constants and helpers for the angle kalman filter
package akf_pkg;

    // default covariance fraction bits (Q2.30)
    localparam int COV_FRAC_BITS = 30;

    // register reset values, Q2.30
    localparam logic [30:0] RST_ANGLE_NOISE = 31'd1073742;
    localparam logic [30:0] RST_BIAS_NOISE  = 31'd3221225;
    localparam logic [30:0] RST_MEAS_NOISE  = 31'd32212255;
    localparam logic [30:0] RST_PERIOD      = 31'd10737418;

    // saturation bounds on a wide sum
    localparam logic signed [67:0] SAT_MAX = 68'sh0_7FFF_FFFF;
    localparam logic signed [67:0] SAT_MIN = -68'sh0_8000_0000;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ANGLE_NOISE = 2'd0,
        REG_BIAS_NOISE  = 2'd1,
        REG_MEAS_NOISE  = 2'd2,
        REG_PERIOD      = 2'd3
    } t_reg;

    // multiply steps of one update, in issue order
    typedef enum logic [3:0] {
        MS_DT_RATE  = 4'd0,
        MS_DT_P11   = 4'd1,
        MS_DT_INNER = 4'd2,
        MS_BPN_DT   = 4'd3,
        MS_K0_Y     = 4'd4,
        MS_K1_Y     = 4'd5,
        MS_K0_P00   = 4'd6,
        MS_K0_P01   = 4'd7,
        MS_K1_P00   = 4'd8,
        MS_K1_P01   = 4'd9
    } t_mstep;

    // controller to datapath commands
    typedef struct packed {
        logic   load;
        logic   rate;
        logic   mul;
        logic   wb;
        logic   inner;
        logic   sy;
        logic   div_start;
        logic   div_sel;
        logic   out_load;
        t_mstep step;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
    } t_sts;

    // clamp a wide signed value to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/akf_div.sv */
// radix-2 restoring divider for the kalman gains, one quotient bit per cycle
module akf_div #(
    parameter int COV_FRAC_BITS = akf_pkg::COV_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    localparam int DW = 32 + COV_FRAC_BITS;
    localparam int CW = $clog2(DW);

    logic          r_busy, r_fin, r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_a;
    logic [32:0]   r_rem, r_d;
    logic          r_neg, r_zero;
    logic signed [31:0] r_q;

    logic [31:0] w_nabs;
    logic [32:0] w_dabs;
    logic [33:0] w_trial, w_diff;
    logic        w_ge;

    // operand magnitudes
    assign w_nabs  = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_dabs  = i_den[32] ? 33'(-i_den) : 33'(i_den);
    // one restoring step
    assign w_trial = {r_rem, r_a[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // dividend/quotient shifter and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= {w_nabs, COV_FRAC_BITS'(0)};
            r_rem  <= '0;
            r_d    <= w_dabs;
            r_neg  <= i_num[31] ^ i_den[32];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_a   <= {r_a[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[32:0] : w_trial[32:0];
        end
    end

    // sign and saturation of the quotient
    always_ff @(posedge i_clk) begin
        if (r_fin) begin
            if (r_zero) begin
                r_q <= '0;
            end else if (r_neg) begin
                r_q <= (r_a > DW'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-r_a);
            end else begin
                r_q <= (r_a > DW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(r_a[31:0]);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hw/rtl/akf_dp.sv */
// datapath: filter state, config registers, shared multiplier and gain divider
module akf_dp #(
    parameter int COV_FRAC_BITS = akf_pkg::COV_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  akf_pkg::t_cmd      i_cmd,
    output akf_pkg::t_sts      o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    input  logic signed [31:0] i_accel_angle,
    input  logic signed [31:0] i_gyro_rate,
    output logic signed [31:0] o_filtered_angle
);
    localparam logic signed [65:0] RND = 66'sd1 <<< (COV_FRAC_BITS - 1);

    // config
    logic [30:0] r_apn, r_bpn, r_mn, r_dt;
    // state
    logic signed [31:0] r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;
    // per-item working registers
    logic signed [31:0] r_acc, r_gyr, r_rate, r_t, r_inner, r_sp00, r_sp01;
    logic signed [31:0] r_k0, r_k1, r_out;
    logic signed [32:0] r_s, r_y;
    logic signed [65:0] r_prod;

    logic signed [32:0] w_ma, w_mb, w_dt;
    logic signed [65:0] w_rnd;
    logic signed [67:0] w_r68;
    logic               w_div_done;
    logic signed [31:0] w_quot;

    assign w_dt  = $signed({2'b00, r_dt});
    assign w_rnd = (r_prod + RND) >>> COV_FRAC_BITS;
    assign w_r68 = 68'(w_rnd);

    // multiplier operand select
    always_comb begin
        case (i_cmd.step)
            akf_pkg::MS_DT_RATE: begin
                w_ma = w_dt; w_mb = 33'(r_rate);
            end
            akf_pkg::MS_DT_P11: begin
                w_ma = w_dt; w_mb = 33'(r_p11);
            end
            akf_pkg::MS_DT_INNER: begin
                w_ma = w_dt; w_mb = 33'(r_inner);
            end
            akf_pkg::MS_BPN_DT: begin
                w_ma = $signed({2'b00, r_bpn}); w_mb = w_dt;
            end
            akf_pkg::MS_K0_Y: begin
                w_ma = 33'(r_k0); w_mb = r_y;
            end
            akf_pkg::MS_K1_Y: begin
                w_ma = 33'(r_k1); w_mb = r_y;
            end
            akf_pkg::MS_K0_P00: begin
                w_ma = 33'(r_k0); w_mb = 33'(r_sp00);
            end
            akf_pkg::MS_K0_P01: begin
                w_ma = 33'(r_k0); w_mb = 33'(r_sp01);
            end
            akf_pkg::MS_K1_P00: begin
                w_ma = 33'(r_k1); w_mb = 33'(r_sp00);
            end
            default: begin
                w_ma = 33'(r_k1); w_mb = 33'(r_sp01);
            end
        endcase
    end

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn <= akf_pkg::RST_ANGLE_NOISE;
            r_bpn <= akf_pkg::RST_BIAS_NOISE;
            r_mn  <= akf_pkg::RST_MEAS_NOISE;
            r_dt  <= akf_pkg::RST_PERIOD;
        end else if (i_cfg_we) begin
            case (akf_pkg::t_reg'(i_cfg_idx))
                akf_pkg::REG_ANGLE_NOISE: r_apn <= i_cfg_data;
                akf_pkg::REG_BIAS_NOISE:  r_bpn <= i_cfg_data;
                akf_pkg::REG_MEAS_NOISE:  r_mn  <= i_cfg_data;
                akf_pkg::REG_PERIOD:      r_dt  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // filter state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_bias  <= '0;
            r_p00   <= '0;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= '0;
        end else if (i_cmd.inner) begin
            r_p01 <= akf_pkg::sat32(68'(r_p01) - 68'(r_t));
            r_p10 <= akf_pkg::sat32(68'(r_p10) - 68'(r_t));
        end else if (i_cmd.wb) begin
            case (i_cmd.step)
                akf_pkg::MS_DT_RATE:  r_angle <= akf_pkg::sat32(68'(r_angle) + w_r68);
                akf_pkg::MS_DT_INNER: r_p00   <= akf_pkg::sat32(68'(r_p00) + w_r68);
                akf_pkg::MS_BPN_DT:   r_p11   <= akf_pkg::sat32(68'(r_p11) + w_r68);
                akf_pkg::MS_K0_Y:     r_angle <= akf_pkg::sat32(68'(r_angle) + w_r68);
                akf_pkg::MS_K1_Y:     r_bias  <= akf_pkg::sat32(68'(r_bias) + w_r68);
                akf_pkg::MS_K0_P00:   r_p00   <= akf_pkg::sat32(68'(r_p00) - w_r68);
                akf_pkg::MS_K0_P01:   r_p01   <= akf_pkg::sat32(68'(r_p01) - w_r68);
                akf_pkg::MS_K1_P00:   r_p10   <= akf_pkg::sat32(68'(r_p10) - w_r68);
                akf_pkg::MS_K1_P01:   r_p11   <= akf_pkg::sat32(68'(r_p11) - w_r68);
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= i_accel_angle;
            r_gyr <= i_gyro_rate;
        end
        if (i_cmd.rate) begin
            r_rate <= akf_pkg::sat32(68'(r_gyr) - 68'(r_bias));
        end
        if (i_cmd.mul) begin
            r_prod <= 66'(w_ma) * 66'(w_mb);
        end
        if (i_cmd.wb && i_cmd.step == akf_pkg::MS_DT_P11) begin
            r_t <= akf_pkg::sat32(w_r68);
        end
        if (i_cmd.inner) begin
            r_inner <= akf_pkg::sat32(68'(r_t) - 68'(r_p01) - 68'(r_p10)
                                      + 68'($signed({1'b0, r_apn})));
        end
        // innovation variance, residual and covariance snapshot
        if (i_cmd.sy) begin
            r_s    <= 33'(r_p00) + $signed({2'b00, r_mn});
            r_y    <= 33'(r_acc) - 33'(r_angle);
            r_sp00 <= r_p00;
            r_sp01 <= r_p01;
        end
        if (w_div_done) begin
            if (i_cmd.div_sel) begin
                r_k1 <= w_quot;
            end else begin
                r_k0 <= w_quot;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_angle;
        end
    end

    // gain divider
    akf_div #(
        .COV_FRAC_BITS(COV_FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (i_cmd.div_sel ? r_p10 : r_p00),
        .i_den  (r_s),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign o_sts.div_done   = w_div_done;
    assign o_filtered_angle = r_out;

endmodule

/* hw/rtl/akf_ctrl.sv */
// controller: sequences one filter update and runs both handshakes
module akf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  akf_pkg::t_sts i_sts,
    output akf_pkg::t_cmd o_cmd
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RATE  = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_WB    = 9'b000001000,
        S_INNER = 9'b000010000,
        S_SY    = 9'b000100000,
        S_DST   = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state          r_state, n_state;
    akf_pkg::t_mstep r_step, n_step;
    logic            r_dsel, n_dsel;
    logic            r_out_valid, n_out_valid;
    logic            w_out_load;

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_dsel  = r_dsel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_RATE;
            end
            S_RATE: begin
                n_step  = akf_pkg::MS_DT_RATE;
                n_state = S_MUL;
            end
            S_MUL: n_state = S_WB;
            S_WB: begin
                case (r_step)
                    akf_pkg::MS_DT_P11: n_state = S_INNER;
                    akf_pkg::MS_BPN_DT: n_state = S_SY;
                    akf_pkg::MS_K1_P01: n_state = S_OUT;
                    default: begin
                        n_step  = akf_pkg::t_mstep'(r_step + 4'd1);
                        n_state = S_MUL;
                    end
                endcase
            end
            S_INNER: begin
                n_step  = akf_pkg::MS_DT_INNER;
                n_state = S_MUL;
            end
            S_SY: begin
                n_dsel  = 1'b0;
                n_state = S_DST;
            end
            S_DST: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (!r_dsel) begin
                        n_dsel  = 1'b1;
                        n_state = S_DST;
                    end else begin
                        n_step  = akf_pkg::MS_K0_Y;
                        n_state = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= akf_pkg::MS_DT_RATE;
            r_dsel      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_dsel      <= n_dsel;
            r_out_valid <= n_out_valid;
        end
    end

    // commands
    always_comb begin
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rate      = (r_state == S_RATE);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.wb        = (r_state == S_WB);
        o_cmd.inner     = (r_state == S_INNER);
        o_cmd.sy        = (r_state == S_SY);
        o_cmd.div_start = (r_state == S_DST);
        o_cmd.div_sel   = r_dsel;
        o_cmd.out_load  = w_out_load;
        o_cmd.step      = r_step;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // an accepted item starts the sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_in_valid |=> (r_state == S_RATE))
        else $error("accepted item did not start an update");

    // the divider never reports done in the cycle after a start
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> !i_sts.div_done)
        else $error("divider finished too early");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && r_out_valid && !i_out_ready |=> (r_state == S_OUT))
        else $error("result overwritten while stalled");

    // a result is only presented after a full update
    a_out_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output step");

endmodule

/* hw/rtl/angle_kalman_filter.sv */
// top level of the two-state angle and gyro bias kalman filter
// Usage:
//   input channel: i_in_valid / o_in_ready carry one accelerometer angle and
//   one gyro rate (signed Q16.16); a transfer takes place when both are high.
//   output channel: o_out_valid / i_out_ready carry the filtered angle.
//   config port: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
//   (0 angle noise, 1 bias noise, 2 measurement noise, 3 sample period, all
//   Q2.30); write only while no update is in flight.
// Sequencing:
//   one item at a time; at the default Q2.30 the time an update takes is set
//   mostly by the two gain divisions in the bit-serial divider plus ten
//   passes through the shared multiplier. The next item is taken as soon
//   as the previous update has moved its result into the output register.
// Reset: clears angle, bias and covariance and loads the default noises and
//   period; the output register comes up empty.
// Stall: a held result stays in the output register; a finished update
//   then waits for it to be taken before input is accepted again.
module angle_kalman_filter #(
    parameter int COV_FRAC_BITS = akf_pkg::COV_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_accel_angle,
    input  logic signed [31:0] i_gyro_rate,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_filtered_angle,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);
    akf_pkg::t_cmd w_cmd;
    akf_pkg::t_sts w_sts;

    // sequencer
    akf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic and state
    akf_dp #(
        .COV_FRAC_BITS(COV_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_accel_angle   (i_accel_angle),
        .i_gyro_rate     (i_gyro_rate),
        .o_filtered_angle(o_filtered_angle)
    );

endmodule

/* verif/tb.sv */
// self-checking testbench for the angle kalman filter top level
`timescale 1ns / 1ps

module tb;

    localparam int CFB = akf_pkg::COV_FRAC_BITS;
    localparam int STALL_LIMIT = 20000;

    // scoreboard: fixed-point filter state and queue of expected angles
    class angle_scoreboard;
        logic [30:0] q_angle, q_bias, r_meas, dt;
        longint est_angle, est_bias, p00, p01, p10, p11;
        logic signed [31:0] angle_q[$];
        int errors;

        function new();
            q_angle = akf_pkg::RST_ANGLE_NOISE;
            q_bias = akf_pkg::RST_BIAS_NOISE;
            r_meas = akf_pkg::RST_MEAS_NOISE;
            dt = akf_pkg::RST_PERIOD;
            est_angle = 0; est_bias = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
            errors = 0;
        endfunction

        function void write_reg(akf_pkg::t_reg idx, logic [30:0] val);
            case (idx)
                akf_pkg::REG_ANGLE_NOISE: q_angle = val;
                akf_pkg::REG_BIAS_NOISE:  q_bias = val;
                akf_pkg::REG_MEAS_NOISE:  r_meas = val;
                akf_pkg::REG_PERIOD:      dt = val;
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // exact product, round half up dropping the covariance fraction
        function longint mul_round(longint a, longint b);
            logic signed [127:0] p;
            p = 128'(a) * 128'(b) + (128'sd1 <<< (CFB - 1));
            return longint'(p >>> CFB);
        endfunction

        function longint kgain(longint num, longint den);
            logic signed [127:0] n;
            if (den == 0) return 0;
            n = 128'(num) <<< CFB;
            return clamp(longint'(n / 128'(den)));
        endfunction

        function void note_input(logic signed [31:0] acc, logic signed [31:0] gyr);
            longint rate, t, inner, s, k0, k1, y, a00, a01, dtl;
            dtl = longint'({1'b0, dt});
            rate = clamp(longint'(gyr) - est_bias);
            est_angle = clamp(est_angle + mul_round(dtl, rate));
            t = clamp(mul_round(dtl, p11));
            inner = clamp(t - p01 - p10 + longint'({1'b0, q_angle}));
            p00 = clamp(p00 + mul_round(dtl, inner));
            p01 = clamp(p01 - t);
            p10 = clamp(p10 - t);
            p11 = clamp(p11 + mul_round(longint'({1'b0, q_bias}), dtl));
            s = p00 + longint'({1'b0, r_meas});
            k0 = kgain(p00, s);
            k1 = kgain(p10, s);
            y = longint'(acc) - est_angle;
            est_angle = clamp(est_angle + mul_round(k0, y));
            est_bias = clamp(est_bias + mul_round(k1, y));
            a00 = p00; a01 = p01;
            p00 = clamp(p00 - mul_round(k0, a00));
            p01 = clamp(p01 - mul_round(k0, a01));
            p10 = clamp(p10 - mul_round(k1, a00));
            p11 = clamp(p11 - mul_round(k1, a01));
            angle_q.push_back(32'(est_angle));
        endfunction

        function void check_result(logic signed [31:0] got);
            logic signed [31:0] want;
            if (angle_q.size() == 0) begin
                $error("filtered_angle: unexpected result %0d", got);
                errors++;
                return;
            end
            want = angle_q.pop_front();
            if (got !== want) begin
                $error("filtered_angle: expected %0d actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_in_valid = 1'b0, i_out_ready = 1'b0, i_cfg_we = 1'b0;
    logic signed [31:0] i_accel_angle = '0, i_gyro_rate = '0;
    logic [1:0] i_cfg_idx = '0;
    logic [30:0] i_cfg_data = '0;
    logic o_in_ready, o_out_valid;
    logic signed [31:0] o_filtered_angle;

    angle_scoreboard sb;
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_off = 0;
    int quiet_cycles = 0;

    angle_kalman_filter i_dut (.*);

    always #6 i_clk = ~i_clk;

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_filtered_angle);
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || hold_off)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // valid stays up between back-to-back items and drops only while idling
    task automatic send_item(logic signed [31:0] acc, logic signed [31:0] gyr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_accel_angle <= acc;
        i_gyro_rate <= gyr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(acc, gyr);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.angle_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic cfg_write(akf_pkg::t_reg idx, logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic cfg_all(logic [30:0] qa, logic [30:0] qb, logic [30:0] r,
                           logic [30:0] t);
        cfg_write(akf_pkg::REG_ANGLE_NOISE, qa);
        cfg_write(akf_pkg::REG_BIAS_NOISE, qb);
        cfg_write(akf_pkg::REG_MEAS_NOISE, r);
        cfg_write(akf_pkg::REG_PERIOD, t);
        i_cfg_we <= 1'b0;
    endtask

    // mostly realistic tilt samples, sometimes full-range noise
    task automatic random_items(int n);
        logic signed [31:0] a, g;
        repeat (n) begin
            if ($urandom_range(9) < 7) begin
                a = $signed($urandom_range(0, 2 * 90 * 65536)) - 90 * 65536;
                g = $signed($urandom_range(0, 2 * 500 * 65536)) - 500 * 65536;
            end else begin
                a = $urandom;
                g = $urandom;
            end
            send_item(a, g);
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes at reset settings
        send_item(32'sh0, 32'sh0);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(32'sh8000_0000, 32'sh8000_0000);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(32'sh0001_0000, -32'sh0001_0000);
        send_item(32'shFFFF_FFFF, 32'sh0000_0001);
        drain();
        // zero innovation variance: zero covariance noise, minimal meas noise
        cfg_all(31'd0, 31'd0, 31'd1, 31'd1);
        send_item(32'sh0010_0000, 32'sh0);
        drain();
        // negative innovation variance via saturated covariance growth
        cfg_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        repeat (6) send_item($urandom, $urandom);
        drain();
        cfg_all(31'd1073741824, 31'd1073741824, 31'd1073741824, 31'd1073741824);
        repeat (6) send_item($urandom, $urandom);
        drain();

        // random phases across settings and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (ph == 0) cfg_all(akf_pkg::RST_ANGLE_NOISE, akf_pkg::RST_BIAS_NOISE,
                                 akf_pkg::RST_MEAS_NOISE, akf_pkg::RST_PERIOD);
            else cfg_all(31'($urandom), 31'($urandom),
                         31'($urandom_range(1, 31'h7FFF_FFFF)), 31'($urandom));
            if (ph == 2) begin
                // long receiver hold-off while inputs keep coming
                fork
                    begin
                        hold_off = 1;
                        repeat (2000) @(posedge i_clk);
                        hold_off = 0;
                    end
                    random_items(140);
                join
            end else random_items(140);
            drain();
        end

        if (sb.errors == 0 && sb.angle_q.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
